// ===== sv/largest_empty_square_finder_defines.svh =====
// Assertion macros used by the checker file of the square finder.
// No dependencies; include by bare file name.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_DEFINES_SVH

// Implication checked outside reset.
`define LESF_AST_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define LESF_AST_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define LESF_AST_NEXT_NR(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lesf_pkg.sv =====
// Package of the largest empty square finder: sizes, register map, stage record.
// No dependencies.
package lesf_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int COL_AW   = $clog2(MAX_COLS);
   localparam int ROW_AW   = $clog2(MAX_ROWS);
   localparam int SCORE_W  = 11;
   localparam int DIM_W    = 11;
   localparam int CHAR_W   = 8;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_OBSTACLE = 2'd0;
   localparam logic [1:0] REG_COLS     = 2'd1;
   localparam logic [1:0] REG_ROWS     = 2'd2;

   // Cell in flight between the read and the score stage
   typedef struct packed {
      logic              obst;      // cell is an obstacle
      logic              border;    // first row or first column
      logic [ROW_AW-1:0] row;
      logic [COL_AW-1:0] col;
      logic              grid_end;  // last cell of the grid
      logic              rd_ok;     // line buffer entry written before
      logic              fwd;       // take score of the previous cell
   } cell_type;

endpackage

// ===== sv/largest_empty_square_finder.sv =====
// Largest empty square finder: maximal-square scoring over a raster stream.
// Depends on lesf_pkg.
//
// Usage:
//  - req channel: one beat per grid cell (req_cell_char), raster order.
//    Beat taken when req_valid is high and req_stall is low.
//  - rsp channel: one beat per grid, after its last cell: square_size,
//    top_row, left_col of the first largest obstacle-free square (all 0
//    when every cell is an obstacle).
//  - csr port (APB style): obstacle_char at 0x0, grid_cols at 0x4,
//    grid_rows at 0x8. Write only while idle. pready is tied high.
// Timing:
//  - One cell per cycle while req_stall is low. The read stage reads the line
//    buffer entry of the cell's column (synchronous RAM); the score stage
//    takes the three-way minimum, writes the score back and updates the best.
//  - Result enters the output register when the last cell is scored.
//  - Back-to-back cells in the same column (one-column grids) take the
//    new score over a forward path instead of the stale RAM word.
// Reset: clears position, best square and the output valid flag and loads
//   register defaults (obstacle 'o', 1024 x 1024). The line buffer is not
//   swept: a fill count marks the written prefix and the rest reads as 0.
// Stall: the output register holds its beat while rsp_stall is high; input
//   keeps flowing unless the score stage holds a last cell of a grid.
module largest_empty_square_finder
   import lesf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // cell stream
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAR_W-1:0]   req_cell_char,
   // result stream
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SCORE_W-1:0]  rsp_square_size,
   output logic [9:0]          rsp_top_row,
   output logic [9:0]          rsp_left_col,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   // ---------------- registers ----------------
   logic [CHAR_W-1:0] obst_ff;
   logic [DIM_W-1:0]  cols_ff;
   logic [DIM_W-1:0]  rows_ff;
   logic [1:0]        reg_idx;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         obst_ff <= CHAR_W'(111);
         cols_ff <= DIM_W'(MAX_COLS);
         rows_ff <= DIM_W'(MAX_ROWS);
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_OBSTACLE: obst_ff <= csr_pwdata[CHAR_W-1:0];
            REG_COLS:     cols_ff <= csr_pwdata[DIM_W-1:0];
            REG_ROWS:     rows_ff <= csr_pwdata[DIM_W-1:0];
            default:      ;  // unmapped: dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OBSTACLE: csr_prdata = {{(32-CHAR_W){1'b0}}, obst_ff};
         REG_COLS:     csr_prdata = {{(32-DIM_W){1'b0}}, cols_ff};
         REG_ROWS:     csr_prdata = {{(32-DIM_W){1'b0}}, rows_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   // effective grid size: 0 acts as 1, clamp at buffer size
   logic [DIM_W-1:0] cols_eff;
   logic [DIM_W-1:0] rows_eff;

   always_comb begin
      priority if (cols_ff == '0)                  cols_eff = DIM_W'(1);
      else if (cols_ff > DIM_W'(MAX_COLS))         cols_eff = DIM_W'(MAX_COLS);
      else                                         cols_eff = cols_ff;
      priority if (rows_ff == '0)                  rows_eff = DIM_W'(1);
      else if (rows_ff > DIM_W'(MAX_ROWS))         rows_eff = DIM_W'(MAX_ROWS);
      else                                         rows_eff = rows_ff;
   end

   // ---------------- stage 1: position and line buffer read ----------------
   logic [COL_AW-1:0]  col_ff, col_in;
   logic [ROW_AW-1:0]  row_ff, row_in;
   logic [COL_AW:0]    fill_ff, fill_in;     // written prefix of line buffer
   logic               row_end, grid_end;
   logic               acc;

   logic               s1_vld_ff, s1_vld_in;
   cell_type           s1_ff, s1_in;
   logic               s1_block, s1_fire;
   logic [SCORE_W-1:0] rd_ff;
   logic [SCORE_W-1:0] fwd_ff;
   logic [SCORE_W-1:0] score;

   logic [SCORE_W-1:0] line_mem [MAX_COLS];

   assign row_end  = (DIM_W'(col_ff) + DIM_W'(1)) >= cols_eff;
   assign grid_end = row_end && ((DIM_W'(row_ff) + DIM_W'(1)) >= rows_eff);

   // score stage only holds a last cell while the output beat is stuck
   assign s1_block  = s1_ff.grid_end && rsp_valid && rsp_stall;
   assign s1_fire   = s1_vld_ff && !s1_block;
   assign req_stall = s1_vld_ff && s1_block;
   assign acc       = req_valid && !req_stall;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (!row_end) begin
            col_in = col_ff + COL_AW'(1);
         end else begin
            col_in = '0;
            row_in = grid_end ? '0 : row_ff + ROW_AW'(1);
         end
      end
   end

   always_comb begin
      s1_in.obst     = (req_cell_char == obst_ff);
      s1_in.border   = (row_ff == '0) || (col_ff == '0);
      s1_in.row      = row_ff;
      s1_in.col      = col_ff;
      s1_in.grid_end = grid_end;
      s1_in.rd_ok    = ({1'b0, col_ff} < fill_ff);
      s1_in.fwd      = s1_fire && (s1_ff.col == col_ff);
   end

   always_comb begin
      priority if (acc)  s1_vld_in = 1'b1;
      else if (s1_fire)  s1_vld_in = 1'b0;
      else               s1_vld_in = s1_vld_ff;
   end

   always_comb begin
      fill_in = fill_ff;
      if (s1_fire && ({1'b0, s1_ff.col} == fill_ff)) fill_in = fill_ff + (COL_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         fill_ff   <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         fill_ff   <= fill_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ff  <= s1_in;
         fwd_ff <= score;
      end
   end

   // line buffer: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (s1_fire) line_mem[s1_ff.col] <= score;
      if (acc)     rd_ff <= line_mem[col_ff];
   end

   // ---------------- stage 2: score, write back, best tracking --------------
   logic [SCORE_W-1:0] up;
   logic [SCORE_W-1:0] left_ff, diag_ff;
   logic [SCORE_W-1:0] best_ff;
   logic [ROW_AW-1:0]  best_row_ff;
   logic [COL_AW-1:0]  best_col_ff;
   logic [SCORE_W-1:0] m_ud;
   logic [SCORE_W-1:0] m_all;
   logic               new_best;
   logic [SCORE_W-1:0] fin_size;
   logic [ROW_AW-1:0]  fin_row;
   logic [COL_AW-1:0]  fin_col;

   always_comb begin
      priority if (s1_ff.fwd) up = fwd_ff;
      else if (s1_ff.rd_ok)   up = rd_ff;
      else                    up = '0;
   end

   assign m_ud  = (diag_ff < up) ? diag_ff : up;
   assign m_all = (m_ud < left_ff) ? m_ud : left_ff;

   always_comb begin
      priority if (s1_ff.obst) score = '0;
      else if (s1_ff.border)   score = SCORE_W'(1);
      else                     score = m_all + SCORE_W'(1);
   end

   assign new_best = score > best_ff;
   assign fin_size = new_best ? score : best_ff;
   assign fin_row  = new_best ? s1_ff.row : best_row_ff;
   assign fin_col  = new_best ? s1_ff.col : best_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff     <= '0;
         best_row_ff <= '0;
         best_col_ff <= '0;
         left_ff     <= '0;
         diag_ff     <= '0;
      end else if (s1_fire) begin
         if (s1_ff.grid_end) begin
            best_ff     <= '0;
            best_row_ff <= '0;
            best_col_ff <= '0;
            left_ff     <= '0;
            diag_ff     <= '0;
         end else begin
            best_ff     <= fin_size;
            best_row_ff <= fin_row;
            best_col_ff <= fin_col;
            left_ff     <= score;
            diag_ff     <= up;
         end
      end
   end

   // ---------------- output register ----------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic               res_load;
   logic [SCORE_W-1:0] size_ff;
   logic [9:0]         top_ff, left_col_ff;

   assign res_load = s1_fire && s1_ff.grid_end;

   always_comb begin
      priority if (res_load)              rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else                                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // corner = bottom-right end + 1 - size, modulo 2^10
   always_ff @(posedge clock) begin
      if (res_load) begin
         size_ff <= fin_size;
         if (fin_size == '0) begin
            top_ff      <= '0;
            left_col_ff <= '0;
         end else begin
            top_ff      <= 10'(fin_row) + 10'd1 - fin_size[9:0];
            left_col_ff <= 10'(fin_col) + 10'd1 - fin_size[9:0];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_square_size = size_ff;
   assign rsp_top_row     = top_ff;
   assign rsp_left_col    = left_col_ff;

endmodule

// ===== sv/lesf_checker.sv =====
// Port-level checks of the largest empty square finder, bound to the top level.
// Depends on lesf_pkg and largest_empty_square_finder_defines.svh.
`include "largest_empty_square_finder_defines.svh"

module lesf_checker
   import lesf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [CHAR_W-1:0]   req_cell_char,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [SCORE_W-1:0]  rsp_square_size,
   input  logic [9:0]          rsp_top_row,
   input  logic [9:0]          rsp_left_col,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   input  logic [31:0]         csr_prdata,
   input  logic                csr_pready
);

   // a stalled result beat stays and keeps its size
   `LESF_AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_square_size), "result beat dropped or changed under stall")

   // an empty-square result carries a zero corner
   `LESF_AST_IMPL(a_zero_corner, clock, reset, rsp_valid && (rsp_square_size == '0), (rsp_top_row == '0) && (rsp_left_col == '0), "zero size with nonzero corner")

   // square never exceeds the buffer width
   `LESF_AST_IMPL(a_size_range, clock, reset, rsp_valid, rsp_square_size <= SCORE_W'(MAX_COLS), "square size out of range")

   // nothing comes out right after reset
   `LESF_AST_NEXT_NR(a_reset_quiet, clock, reset, !rsp_valid && csr_pready, "result or pready wrong after reset")

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (.*);

// ===== dv/tb_largest_empty_square_finder.sv =====
// Testbench of the largest empty square finder: raster grids go in, square results are checked
// against an in-bench maximal-square scorer. Depends on lesf_pkg and the finder RTL.
module tb_largest_empty_square_finder;
   import lesf_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 4000;  // cycles with no beat, no csr access
   localparam int RANDOM_CELLS  = 850;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [SCORE_W-1:0] size;
      logic [9:0]         top_row;
      logic [9:0]         left_col;
   } square_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CHAR_W-1:0]   req_cell_char;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [SCORE_W-1:0]  rsp_square_size;
   logic [9:0]          rsp_top_row;
   logic [9:0]          rsp_left_col;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [3:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   largest_empty_square_finder dut (.*);

   // Register shadow, updated when a write completes
   logic [CHAR_W-1:0]  obstacle_code;
   logic [DIM_W-1:0]   cols_reg;
   logic [DIM_W-1:0]   rows_reg;

   // Scorer state: line buffer of the previous row, neighbors, position, best so far
   logic [SCORE_W-1:0] line_scores [MAX_COLS];
   logic [SCORE_W-1:0] left_sc;
   logic [SCORE_W-1:0] diag_sc;
   logic [SCORE_W-1:0] best_size;
   logic [COL_AW-1:0]  col_pos;
   logic [COL_AW-1:0]  best_col;
   logic [ROW_AW-1:0]  row_pos;
   logic [ROW_AW-1:0]  best_row;

   logic [CHAR_W-1:0]  cell_chars_pending [$];   // cells not yet put on the bus
   square_type         squares_expected [$];     // results owed by the block

   logic           req_taken;      // beat on the bus was accepted at the last rising edge
   int             burst_left;
   int             gap_left;
   stall_mode_type stall_mode;
   int             stall_age;
   int             idle_cycles;
   int             fault_count;
   int             cells_sent;
   int             squares_checked;
   int             settings_done;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // 0 acts as 1, anything past the buffer acts as the buffer size
   function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : int'(v);
   endfunction

   function automatic void compare_value(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
         fault_count++;
      end
   endfunction

   // Scores one accepted cell. Returns 1 when the cell closes a grid, with the square in sq.
   function automatic bit score_cell(input logic [CHAR_W-1:0] ch, output square_type sq);
      int cols;
      int rows;
      int c;
      int r;
      logic [SCORE_W-1:0] up;
      logic [SCORE_W-1:0] score;
      cols = clamp_dim(cols_reg, MAX_COLS);
      rows = clamp_dim(rows_reg, MAX_ROWS);
      c = int'(col_pos);
      r = int'(row_pos);
      up = line_scores[c];
      if (ch == obstacle_code) begin
         score = '0;
      end else if (r == 0 || c == 0) begin
         score = SCORE_W'(1);
      end else begin
         score = (diag_sc < up) ? diag_sc : up;
         if (left_sc < score) score = left_sc;
         score = score + 1'b1;
      end
      diag_sc = up;
      line_scores[c] = score;
      left_sc = score;
      // strictly larger only: ties keep the first in raster order
      if (score > best_size) begin
         best_size = score;
         best_row = ROW_AW'(r);
         best_col = COL_AW'(c);
      end
      sq = '0;
      // a column (row) at or past the last in use ends the row (grid)
      if (c + 1 < cols) begin
         col_pos = COL_AW'(c + 1);
         return 1'b0;
      end
      col_pos = '0;
      if (r + 1 < rows) begin
         row_pos = ROW_AW'(r + 1);
         return 1'b0;
      end
      if (best_size != 0) begin
         sq.size     = best_size;
         sq.top_row  = 10'(int'(best_row) + 1 - int'(best_size));
         sq.left_col = 10'(int'(best_col) + 1 - int'(best_size));
      end
      row_pos = '0;
      best_size = '0;
      best_row = '0;
      best_col = '0;
      left_sc = '0;
      diag_sc = '0;
      return 1'b1;
   endfunction

   // Cell beats accepted here feed the scorer
   always @(posedge clock) begin : cell_accept
      square_type sq;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         cells_sent++;
         if (score_cell(req_cell_char, sq)) squares_expected.push_back(sq);
      end
   end

   // Cell driver: bursts of random length, random gaps between them
   always @(negedge clock) begin : cell_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled beat holds as it is
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (cell_chars_pending.size() > 0) begin
         req_valid <= 1'b1;
         req_cell_char <= cell_chars_pending.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result stall: random modes held for random stretches, including long stall-free runs
   always @(negedge clock) begin : result_stall_pattern
      if (stall_age == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_age <= $urandom_range(20, 120);
      end else begin
         stall_age <= stall_age - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 7) != 0);
         default:     rsp_stall <= stall_age[2];
      endcase
   end

   // Result checker: each beat against the oldest owed square
   always @(posedge clock) begin : result_check
      square_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (squares_expected.size() == 0) begin
            $display("%0t: square result with none expected: size %0d row %0d col %0d",
                     $time, rsp_square_size, rsp_top_row, rsp_left_col);
            fault_count++;
         end else begin
            want = squares_expected.pop_front();
            compare_value("square_size", 32'(want.size), 32'(rsp_square_size));
            compare_value("top_row", 32'(want.top_row), 32'(rsp_top_row));
            compare_value("left_col", 32'(want.left_col), 32'(rsp_left_col));
            squares_checked++;
         end
      end
   end

   // Watchdog: any beat or csr access counts as progress
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d squares still owed",
                  $time, IDLE_LIMIT, squares_expected.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Wait for the cell queue to drain and every owed square to arrive, then let the
   // pipeline settle (a partial grid leaves cells in flight with no result).
   task automatic wait_drained();
      while (cell_chars_pending.size() != 0 || req_valid || squares_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_OBSTACLE: obstacle_code = value[CHAR_W-1:0];
         REG_COLS:     cols_reg = value[DIM_W-1:0];
         REG_ROWS:     rows_reg = value[DIM_W-1:0];
         default:      ;  // no register there, write dropped
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check(input logic [1:0] idx, input string what, input logic [31:0] want);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      compare_value(what, want, csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // New setting once idle; junk in the upper data bits must be dropped, as must the
   // write to the unused address. Read back all three afterwards.
   task automatic program_grid(input logic [CHAR_W-1:0] obst, input logic [DIM_W-1:0] cols,
                               input logic [DIM_W-1:0] rows);
      wait_drained();
      csr_write(REG_OBSTACLE, ($urandom() & 32'hFFFF_FF00) | 32'(obst));
      csr_write(REG_COLS, ($urandom() & 32'hFFFF_F800) | 32'(cols));
      csr_write(REG_ROWS, ($urandom() & 32'hFFFF_F800) | 32'(rows));
      csr_write(REG_UNUSED, $urandom());
      csr_check(REG_OBSTACLE, "obstacle_char readback", 32'(obst));
      csr_check(REG_COLS, "grid_cols readback", 32'(cols));
      csr_check(REG_ROWS, "grid_rows readback", 32'(rows));
      settings_done++;
   endtask

   // Queue random cells; obst_pct sets the share forced to the obstacle code
   task automatic queue_cells(input int count, input int obst_pct);
      logic [CHAR_W-1:0] ch;
      repeat (count) begin
         if ($urandom_range(1, 100) <= obst_pct) ch = obstacle_code;
         else ch = CHAR_W'($urandom_range(0, 255));
         cell_chars_pending.push_back(ch);
      end
   endtask

   initial begin : stimulus
      int random_cells;
      int cells;
      int grids;
      int pct;
      logic [CHAR_W-1:0] obst;
      logic [DIM_W-1:0]  cols;
      logic [DIM_W-1:0]  rows;

      reset = 1'b1;
      req_valid = 1'b0;
      req_cell_char = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      stall_mode = STALL_NONE;
      stall_age = 0;
      idle_cycles = 0;
      fault_count = 0;
      cells_sent = 0;
      squares_checked = 0;
      settings_done = 0;
      random_cells = 0;
      obstacle_code = 8'd111;
      cols_reg = 11'd1024;
      rows_reg = 11'd1024;
      foreach (line_scores[i]) line_scores[i] = '0;
      left_sc = '0;
      diag_sc = '0;
      best_size = '0;
      col_pos = '0;
      best_col = '0;
      row_pos = '0;
      best_row = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults out of reset
      csr_check(REG_OBSTACLE, "obstacle_char reset", 32'd111);
      csr_check(REG_COLS, "grid_cols reset", 32'd1024);
      csr_check(REG_ROWS, "grid_rows reset", 32'd1024);

      // 3x3 with two equal 2x2 squares: the first in raster order wins.
      // Extreme characters 0x00 and 0xFF sit among the empty cells.
      program_grid(8'd111, 11'd3, 11'd3);
      cell_chars_pending = '{8'h00, 8'hFF, 8'd111,
                             8'h2E, 8'h41, 8'h7E,
                             8'd111, 8'h20, 8'h80};
      // every cell an obstacle: all-zero result
      repeat (9) cell_chars_pending.push_back(8'd111);
      // zero sizes act as a 1x1 grid; obstacle at the top code
      program_grid(8'hFF, 11'd0, 11'd0);
      cell_chars_pending.push_back(8'hFF);
      cell_chars_pending.push_back(8'h00);

      // one row past the buffer size (clamped): lone empty cell in the last column
      obst = CHAR_W'($urandom_range(0, 255));
      program_grid(obst, 11'd2047, 11'd1);
      repeat (MAX_COLS - 1) cell_chars_pending.push_back(obst);
      cell_chars_pending.push_back(obst ^ 8'h01);

      // Random phases: mostly whole grids of random content, now and then a partial
      // grid so the next setting lands mid-grid.
      while (random_cells < RANDOM_CELLS) begin
         case ($urandom_range(0, 5))
            0:       obst = 8'h00;
            1:       obst = 8'hFF;
            2:       obst = 8'd111;
            default: obst = CHAR_W'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 9))
            0:       cols = 11'd0;
            1:       cols = 11'd1;
            2, 3:    cols = DIM_W'($urandom_range(9, 24));
            default: cols = DIM_W'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 9))
            0:       rows = 11'd0;
            1:       rows = 11'd1;
            2, 3:    rows = DIM_W'($urandom_range(9, 24));
            default: rows = DIM_W'($urandom_range(2, 8));
         endcase
         program_grid(obst, cols, rows);
         cells = clamp_dim(cols, MAX_COLS) * clamp_dim(rows, MAX_ROWS);
         grids = $urandom_range(1, 4);
         repeat (grids) begin
            case ($urandom_range(0, 5))
               0:       pct = 0;
               1:       pct = 100;
               2:       pct = 30;
               3:       pct = 10;
               default: pct = 3;
            endcase
            queue_cells(cells, pct);
            random_cells += cells;
         end
         if (cells > 1 && $urandom_range(0, 3) == 0) begin
            pct = $urandom_range(1, cells - 1);
            queue_cells(pct, 5);
            random_cells += pct;
         end
      end

      wait_drained();
      $display("ran %0d cells through %0d register settings and checked %0d squares",
               cells_sent, settings_done, squares_checked);
      $display("grids from 1x1 to a full-width row, ties, mid-grid resizes");
      if (fault_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== largest_empty_square_finder.f =====
+incdir+sv
sv/lesf_pkg.sv
sv/largest_empty_square_finder.sv
sv/lesf_checker.sv
dv/tb_largest_empty_square_finder.sv
